/* rtl/core/radial_falloff_cell_blend_macros.svh */
// shared assertion macros
`ifndef RADIAL_FALLOFF_CELL_BLEND_MACROS_SVH
`define RADIAL_FALLOFF_CELL_BLEND_MACROS_SVH

// property checked at every clock edge outside reset
`define RFCB_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// implication checked on the next clock edge
`define RFCB_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/core/rfcb_pkg.sv */
package rfcb_pkg;

  localparam int unsigned GridWidth  = 1024;
  localparam int unsigned GridHeight = 1024;
  localparam int unsigned GridBits   = 13;
  localparam int unsigned SqBits     = 21;
  localparam int unsigned RootBits   = 19;
  localparam int unsigned QuotBits   = 15;
  localparam int unsigned NumBits    = 25;
  localparam int unsigned AddrBits   = 5;
  localparam logic [15:0] ProbOne    = 16'd32768;

  typedef enum logic [2:0] {
    RegCenterCol = 3'd0,
    RegCenterRow = 3'd1,
    RegRadius    = 3'd2,
    RegToward    = 3'd3,
    RegAway      = 3'd4,
    RegBlend     = 3'd5
  } reg_idx_e;

  typedef struct packed {
    logic [9:0]  cell_col;
    logic [9:0]  cell_row;
    logic [15:0] prev_toward;
    logic [15:0] prev_away;
  } cell_in_t;

  typedef struct packed {
    logic        inside_res;
    logic [15:0] new_toward;
    logic [15:0] new_away;
  } cell_out_t;

  typedef struct packed {
    logic [9:0]  center_col;
    logic [9:0]  center_row;
    logic [9:0]  brush_radius;
    logic [15:0] toward_level;
    logic [15:0] away_level;
    logic [15:0] blend_factor;
  } cfg_t;

  typedef struct packed {
    logic        in_brush;
    logic [15:0] pt;
    logic [15:0] pa;
  } side_t;

endpackage

/* rtl/core/rfcb_dist.sv */
module rfcb_dist import rfcb_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                en_i,
  input  logic                in_valid_i,
  input  cell_in_t            in_i,
  input  cfg_t                cfg_i,
  output logic                valid_o,
  output logic [RootBits-1:0] dist_o,
  output side_t               side_o
);

  logic [9:0]        dx_q, dy_q;
  side_t             side0_q, side1_q;
  logic              vld0_q, vld1_q;
  logic [SqBits-1:0] s1_q;
  logic [19:0]       rsq_q;

  logic [RootBits:0]   vld_q;
  logic [SqBits-1:0]   s_q    [RootBits+1];
  logic [SqBits-1:0]   rem_q  [RootBits+1];
  logic [RootBits-1:0] root_q [RootBits+1];
  side_t               sd_q   [RootBits+1];

  logic on_grid;
  logic [SqBits-1:0] s_sum;

  assign on_grid = ({3'b0, in_i.cell_col} < GridBits'(GridWidth)) &&
                   ({3'b0, in_i.cell_row} < GridBits'(GridHeight));
  assign s_sum = SqBits'(dx_q * dx_q) + SqBits'(dy_q * dy_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld0_q <= 1'b0;
      vld1_q <= 1'b0;
    end else if (en_i) begin
      vld0_q <= in_valid_i;
      vld1_q <= vld0_q;
    end
  end

  always_ff @(posedge clk_i) begin
    rsq_q <= 20'(cfg_i.brush_radius * cfg_i.brush_radius);
    if (en_i) begin
      dx_q <= (in_i.cell_col >= cfg_i.center_col) ? in_i.cell_col - cfg_i.center_col
                                                  : cfg_i.center_col - in_i.cell_col;
      dy_q <= (in_i.cell_row >= cfg_i.center_row) ? in_i.cell_row - cfg_i.center_row
                                                  : cfg_i.center_row - in_i.cell_row;
      side0_q <= '{in_brush: on_grid, pt: in_i.prev_toward, pa: in_i.prev_away};
      s1_q    <= s_sum;
      side1_q <= '{in_brush: side0_q.in_brush && (cfg_i.brush_radius != '0) &&
                             (s_sum < {1'b0, rsq_q}),
                   pt: side0_q.pt, pa: side0_q.pa};
    end
  end

  assign vld_q[0]  = vld1_q;
  assign s_q[0]    = s1_q;
  assign rem_q[0]  = '0;
  assign root_q[0] = '0;
  assign sd_q[0]   = side1_q;

  // one root bit per stage, MSB first
  for (genvar k = 0; k < RootBits; k++) begin : g_root
    localparam int unsigned B = RootBits - 1 - k;
    logic [37:0]           vf;
    logic [SqBits+1:0]     rem2, trial;
    logic                  ge;
    assign vf    = {1'b0, s_q[k], 16'b0};
    assign rem2  = {rem_q[k], vf[2*B+1 -: 2]};
    assign trial = {2'b0, root_q[k], 2'b01};
    assign ge    = rem2 >= trial;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[k+1] <= 1'b0;
      end else if (en_i) begin
        vld_q[k+1] <= vld_q[k];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        s_q[k+1]    <= s_q[k];
        rem_q[k+1]  <= ge ? SqBits'(rem2 - trial) : rem2[SqBits-1:0];
        root_q[k+1] <= {root_q[k][RootBits-2:0], ge};
        sd_q[k+1]   <= sd_q[k];
      end
    end
  end

  assign valid_o = vld_q[RootBits];
  assign dist_o  = root_q[RootBits];
  assign side_o  = sd_q[RootBits];

endmodule

/* rtl/core/rfcb_div.sv */
module rfcb_div import rfcb_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                en_i,
  input  logic                valid_i,
  input  logic [RootBits-1:0] dist_i,
  input  side_t               side_i,
  input  logic [9:0]          radius_i,
  output logic                valid_o,
  output logic [QuotBits-1:0] ratio_o,
  output side_t               side_o
);

  logic [QuotBits:0]    vld_q;
  logic [NumBits-1:0]   num_q [QuotBits+1];
  logic [9:0]           rem_q [QuotBits+1];
  logic [QuotBits-1:0]  quo_q [QuotBits+1];
  side_t                sd_q  [QuotBits+1];

  // inside cells have dist below 2^18 and a quotient below 2^15
  assign vld_q[0] = valid_i;
  assign num_q[0] = {dist_i[RootBits-2:0], 7'b0};
  assign rem_q[0] = num_q[0][NumBits-1 -: 10];
  assign quo_q[0] = '0;
  assign sd_q[0]  = side_i;

  for (genvar k = 0; k < QuotBits; k++) begin : g_quo
    localparam int unsigned B = QuotBits - 1 - k;
    logic [10:0] t;
    logic        ge;
    assign t  = {rem_q[k], num_q[k][B]};
    assign ge = t >= {1'b0, radius_i};

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[k+1] <= 1'b0;
      end else if (en_i) begin
        vld_q[k+1] <= vld_q[k];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        num_q[k+1] <= num_q[k];
        rem_q[k+1] <= ge ? 10'(t - {1'b0, radius_i}) : t[9:0];
        quo_q[k+1] <= {quo_q[k][QuotBits-2:0], ge};
        sd_q[k+1]  <= sd_q[k];
      end
    end
  end

  assign valid_o = vld_q[QuotBits];
  assign ratio_o = quo_q[QuotBits];
  assign side_o  = sd_q[QuotBits];

endmodule

/* rtl/core/rfcb_mix.sv */
module rfcb_mix import rfcb_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                en_i,
  input  logic                valid_i,
  input  logic [QuotBits-1:0] ratio_i,
  input  side_t               side_i,
  input  cfg_t                cfg_i,
  output logic                valid_o,
  output cell_out_t           out_o
);

  logic               vld_a_q, vld_b_q, vld_c_q;
  side_t              side_a_q, side_b_q;
  logic [QuotBits-1:0] ratio_a_q;
  logic signed [33:0] pt_a_q, pa_a_q;
  logic signed [49:0] pt_b_q, pa_b_q;
  logic signed [16:0] dt, da, bf;
  cell_out_t          out_q;

  function automatic logic [15:0] settle(logic signed [49:0] p, logic [15:0] lvl);
    logic signed [19:0] term;
    logic signed [20:0] val;
    term = 20'(p >>> 30);
    val  = $signed({5'b0, lvl}) + 21'(term);
    if (val < 0) begin
      return '0;
    end else if (val > $signed({5'b0, ProbOne})) begin
      return ProbOne;
    end
    return val[15:0];
  endfunction

  assign bf = $signed({1'b0, cfg_i.blend_factor});
  assign dt = $signed({1'b0, side_i.pt}) - $signed({1'b0, cfg_i.toward_level});
  assign da = $signed({1'b0, side_i.pa}) - $signed({1'b0, cfg_i.away_level});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_a_q <= 1'b0;
      vld_b_q <= 1'b0;
      vld_c_q <= 1'b0;
    end else if (en_i) begin
      vld_a_q <= valid_i;
      vld_b_q <= vld_a_q;
      vld_c_q <= vld_b_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      pt_a_q    <= dt * bf;
      pa_a_q    <= da * bf;
      ratio_a_q <= ratio_i;
      side_a_q  <= side_i;
      pt_b_q    <= pt_a_q * $signed({1'b0, ratio_a_q});
      pa_b_q    <= pa_a_q * $signed({1'b0, ratio_a_q});
      side_b_q  <= side_a_q;
      if (side_b_q.in_brush) begin
        out_q <= '{inside_res: 1'b1,
                   new_toward: settle(pt_b_q, cfg_i.toward_level),
                   new_away:   settle(pa_b_q, cfg_i.away_level)};
      end else begin
        out_q <= '{inside_res: 1'b0, new_toward: side_b_q.pt, new_away: side_b_q.pa};
      end
    end
  end

  assign valid_o = vld_c_q;
  assign out_o   = out_q;

endmodule

/* rtl/core/radial_falloff_cell_blend.sv */
// Circular-brush blend of one grid cell per word. Each input word carries a cell's
// coordinates and its two Q1.15 probabilities; one output word returns per input, in
// order. Fully pipelined: a new word can enter every clock unless the output stalls.
// It computes distance squared, bit-per-stage square root and divide by radius, the
// two multiplies and the clamp into the output register. An output stall while
// out_valid_o is high freezes the whole pipe and is reflected on in_stall_o in the
// same cycle. Registers at byte addresses 0,4,..,20: center col, center row, radius,
// toward level, away level, blend factor; write only while the pipe is empty.
`include "radial_falloff_cell_blend_macros.svh"

module radial_falloff_cell_blend import rfcb_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  cell_in_t            in_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output cell_out_t           out_o,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [AddrBits-1:0] paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready
);

  cfg_t                cfg_q;
  logic                en;
  reg_idx_e            idx;
  logic                d_valid, q_valid;
  logic [RootBits-1:0] root_dist;
  logic [QuotBits-1:0] ratio;
  side_t               d_side, q_side;

  assign en         = !out_valid_o || !out_stall_i;
  assign in_stall_o = !en;
  assign pready     = 1'b1;
  assign idx        = reg_idx_e'(paddr[AddrBits-1:2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else if (psel && penable && pwrite) begin
      case (idx)
        RegCenterCol: cfg_q.center_col   <= pwdata[9:0];
        RegCenterRow: cfg_q.center_row   <= pwdata[9:0];
        RegRadius:    cfg_q.brush_radius <= pwdata[9:0];
        RegToward:    cfg_q.toward_level <= pwdata[15:0];
        RegAway:      cfg_q.away_level   <= pwdata[15:0];
        RegBlend:     cfg_q.blend_factor <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      RegCenterCol: prdata = {22'b0, cfg_q.center_col};
      RegCenterRow: prdata = {22'b0, cfg_q.center_row};
      RegRadius:    prdata = {22'b0, cfg_q.brush_radius};
      RegToward:    prdata = {16'b0, cfg_q.toward_level};
      RegAway:      prdata = {16'b0, cfg_q.away_level};
      RegBlend:     prdata = {16'b0, cfg_q.blend_factor};
      default:      prdata = '0;
    endcase
  end

  rfcb_dist u_dist (
    .clk_i, .rst_ni, .en_i(en), .in_valid_i(in_valid_i && en), .in_i, .cfg_i(cfg_q),
    .valid_o(d_valid), .dist_o(root_dist), .side_o(d_side)
  );

  rfcb_div u_div (
    .clk_i, .rst_ni, .en_i(en), .valid_i(d_valid), .dist_i(root_dist), .side_i(d_side),
    .radius_i(cfg_q.brush_radius), .valid_o(q_valid), .ratio_o(ratio), .side_o(q_side)
  );

  rfcb_mix u_mix (
    .clk_i, .rst_ni, .en_i(en), .valid_i(q_valid), .ratio_i(ratio), .side_i(q_side),
    .cfg_i(cfg_q), .valid_o(out_valid_o), .out_o
  );

  `RFCB_ASSERT(a_stall_map, in_stall_o == (out_valid_o && out_stall_i),
               "stall not from output")
  `RFCB_ASSERT(a_clamp,
               !(out_valid_o && out_o.inside_res) ||
               (out_o.new_toward <= ProbOne && out_o.new_away <= ProbOne),
               "inside result out of range")
  `RFCB_ASSERT_NEXT(a_out_hold, out_valid_o && out_stall_i, out_valid_o,
                    "stalled word dropped")

endmodule
